// File: rtl/tlr_pkg.sv
`timescale 1ns / 1ps
package tlr_pkg;

  localparam logic [1:0] CMD_PUSH   = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_REPORT = 2'd2;

  localparam logic [1:0] KIND_EMPTY  = 2'd0;
  localparam logic [1:0] KIND_LINE   = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  localparam logic [7:0]  NEWLINE_BYTE = 8'd10;
  localparam logic [3:0]  TAG_LEN      = 4'd9;
  localparam logic [15:0] DROP_MAX     = 16'hFFFF;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } tlr_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  out_byte;
    logic        last_of_line;
    logic [15:0] dropped_lines;
  } tlr_out_t;

  typedef struct packed {
    logic done;
    logic keep;
  } tlr_line_t;

  function automatic logic [7:0] tag_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h5B;
      4'd1:    b = 8'h4C;
      4'd2:    b = 8'h4C;
      4'd3:    b = 8'h50;
      4'd4:    b = 8'h20;
      4'd5:    b = 8'h76;
      4'd6:    b = 8'h3D;
      4'd7:    b = 8'h32;
      4'd8:    b = 8'h5D;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/tagged_line_drop_oldest_ring_core.sv
`timescale 1ns / 1ps
// Channel | Ports                          | Beat
// input   | in_valid in_stall in_data      | cmd, data_byte
// result  | out_valid out_stall out_data   | kind, out_byte, last_of_line, dropped_lines
//
// One beat per cycle while in_stall is low; a result goes from its command beat
// through the data store read, then through the output register.
// Lines are assembled straight into a free slot of a RING_LINES+1 slot store,
// so a kept line costs no copy; the length store is read as the oldest line
// changes, and its data is forwarded in the next cycle.
// Reset is synchronous; no store needs a clearing pass.
// A stalled result holds read and report beats; push beats are still taken.
module tagged_line_drop_oldest_ring_core import tlr_pkg::*; #(
  parameter int RING_LINES = 32,
  parameter int LINE_BYTES = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  tlr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output tlr_out_t out_data
);

  localparam int SLOTS = RING_LINES + 1;
  localparam int SW    = $clog2(SLOTS);
  localparam int OW    = $clog2(LINE_BYTES);
  localparam int AW    = SW + OW;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    return (s == SW'(RING_LINES)) ? '0 : s + 1'b1;
  endfunction

  logic [SW-1:0] head_r, head_nxt;
  logic [SW-1:0] tail_r, tail_nxt;
  logic [SW-1:0] count_r, count_nxt;
  logic [OW-1:0] off_r, off_nxt;
  logic [15:0]   drop_r, drop_nxt;
  logic [OW-1:0] tail_len_r, tail_len_nxt;
  logic          len_pend_r, fetch;

  logic          s1_valid_r, s1_valid_nxt;
  logic [1:0]    s1_kind_r, s1_kind_nxt;
  logic          s1_last_r, s1_last_nxt;
  logic [15:0]   s1_drop_r, s1_drop_nxt;
  logic          out_valid_r;
  tlr_out_t      out_data_r;

  logic          fire, wants_res, res_fire, rd_fire, out_move, store, last;
  logic [OW-1:0] tail_len;

  logic          wr_en;
  logic [OW-1:0] wr_off, line_size, len_rdata;
  tlr_line_t     line;
  logic [7:0]    byte_rdata;

  assign out_move  = !out_valid_r || !out_stall;
  assign wants_res = (in_data.cmd == CMD_READ) || (in_data.cmd == CMD_REPORT);
  assign in_stall  = wants_res && s1_valid_r && !out_move;
  assign fire      = in_valid && !in_stall;
  assign res_fire  = fire && wants_res;
  assign rd_fire   = fire && (in_data.cmd == CMD_READ) && (count_r != '0);
  assign store     = line.done && line.keep;
  assign tail_len  = len_pend_r ? len_rdata : tail_len_r;
  assign last      = ({1'b0, off_r} + 1'b1) >= {1'b0, tail_len};

  tlr_asm #(
    .LINE_BYTES(LINE_BYTES)
  ) u_asm (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fire && (in_data.cmd == CMD_PUSH)),
    .push_byte(in_data.data_byte),
    .wr_en    (wr_en),
    .wr_off   (wr_off),
    .line     (line),
    .line_size(line_size)
  );

  tlr_ram #(
    .WIDTH(8),
    .DEPTH(SLOTS << OW)
  ) u_bytes (
    .clk  (clk),
    .we   (wr_en),
    .waddr({head_r, wr_off}),
    .wdata(in_data.data_byte),
    .re   (rd_fire),
    .raddr({tail_r, off_r}),
    .rdata(byte_rdata)
  );

  tlr_ram #(
    .WIDTH(OW),
    .DEPTH(SLOTS)
  ) u_lens (
    .clk  (clk),
    .we   (store),
    .waddr(head_r),
    .wdata(line_size),
    .re   (fetch),
    .raddr(tail_nxt),
    .rdata(len_rdata)
  );

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    count_nxt    = count_r;
    off_nxt      = off_r;
    drop_nxt     = drop_r;
    tail_len_nxt = tail_len;
    fetch        = 1'b0;
    s1_kind_nxt  = s1_kind_r;
    s1_last_nxt  = s1_last_r;
    s1_drop_nxt  = s1_drop_r;

    if (store) begin
      head_nxt = next_slot(head_r);
      if (count_r == SW'(RING_LINES)) begin
        tail_nxt = next_slot(tail_r);
        off_nxt  = '0;
        fetch    = 1'b1;
        if (drop_r != DROP_MAX) begin
          drop_nxt = drop_r + 16'd1;
        end
      end else begin
        count_nxt = count_r + 1'b1;
        if (count_r == '0) begin
          tail_len_nxt = line_size;
        end
      end
    end

    if (res_fire) begin
      s1_kind_nxt = KIND_EMPTY;
      s1_last_nxt = 1'b0;
      s1_drop_nxt = '0;
      if (in_data.cmd == CMD_REPORT) begin
        s1_kind_nxt = KIND_REPORT;
        s1_drop_nxt = drop_r;
        drop_nxt    = '0;
      end else if (rd_fire) begin
        s1_kind_nxt = KIND_LINE;
        s1_last_nxt = last;
        if (last) begin
          tail_nxt  = next_slot(tail_r);
          count_nxt = count_r - 1'b1;
          off_nxt   = '0;
          fetch     = (count_r != SW'(1));
        end else begin
          off_nxt = off_r + 1'b1;
        end
      end
    end

    if (res_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (out_move) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      off_r       <= '0;
      drop_r      <= '0;
      len_pend_r  <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      count_r    <= count_nxt;
      off_r      <= off_nxt;
      drop_r     <= drop_nxt;
      len_pend_r <= fetch;
      s1_valid_r <= s1_valid_nxt;
      if (out_move) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    tail_len_r <= tail_len_nxt;
    s1_kind_r  <= s1_kind_nxt;
    s1_last_r  <= s1_last_nxt;
    s1_drop_r  <= s1_drop_nxt;
    if (out_move && s1_valid_r) begin
      out_data_r.kind          <= s1_kind_r;
      out_data_r.out_byte      <= (s1_kind_r == KIND_LINE) ? byte_rdata : 8'd0;
      out_data_r.last_of_line  <= s1_last_r;
      out_data_r.dropped_lines <= s1_drop_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= SW'(RING_LINES))
    else $error("line count above ring size");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r))
    else $error("empty ring with head and tail apart");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall && s1_valid_r))
    else $error("input stalled without output backpressure");

  a_fetch_live: assert property (@(posedge clk) disable iff (!rst_n)
    len_pend_r |-> (count_r != '0))
    else $error("length fetch for an empty ring");

  a_off_live: assert property (@(posedge clk) disable iff (!rst_n)
    (off_r != '0) |-> (count_r != '0))
    else $error("read offset held with no stored line");

endmodule

// File: rtl/tlr_ram.sv
`timescale 1ns / 1ps
module tlr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/tlr_asm.sv
`timescale 1ns / 1ps
module tlr_asm import tlr_pkg::*; #(
  parameter int LINE_BYTES = 256,
  localparam int OW = $clog2(LINE_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [7:0]    push_byte,
  output logic          wr_en,
  output logic [OW-1:0] wr_off,
  output tlr_line_t     line,
  output logic [OW-1:0] line_size
);

  localparam logic [OW-1:0] CAP = OW'(LINE_BYTES - 1);

  logic [OW-1:0] len_r, len_nxt;
  logic [3:0]    prog_r, prog_nxt;
  logic          matched_r, matched_nxt;
  logic          stopped_r, stopped_nxt;
  logic          is_nl;

  assign is_nl     = (push_byte == NEWLINE_BYTE);
  assign wr_en     = push && !is_nl && (len_r < CAP);
  assign wr_off    = len_r;
  assign line_size = len_r;
  assign line.done = push && is_nl;
  assign line.keep = matched_r;

  always_comb begin
    len_nxt     = len_r;
    prog_nxt    = prog_r;
    matched_nxt = matched_r;
    stopped_nxt = stopped_r;
    if (line.done) begin
      len_nxt     = '0;
      prog_nxt    = '0;
      matched_nxt = 1'b0;
      stopped_nxt = 1'b0;
    end else if (wr_en) begin
      len_nxt = len_r + 1'b1;
      if (push_byte == 8'd0) begin
        stopped_nxt = 1'b1;
      end else if (!matched_r && !stopped_r) begin
        if (prog_r < TAG_LEN && push_byte == tag_byte(prog_r)) begin
          prog_nxt = prog_r + 4'd1;
        end else begin
          prog_nxt = (push_byte == tag_byte(4'd0)) ? 4'd1 : 4'd0;
        end
        if (prog_nxt >= TAG_LEN) begin
          matched_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      prog_r    <= '0;
      matched_r <= 1'b0;
      stopped_r <= 1'b0;
    end else begin
      len_r     <= len_nxt;
      prog_r    <= prog_nxt;
      matched_r <= matched_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

// File: bench/line_ring_checker.sv
`timescale 1ns / 1ps
module line_ring_checker import tlr_pkg::*; #(
  parameter int RING_LINES = 32,
  parameter int LINE_BYTES = 256
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  tlr_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  tlr_out_t out_data,
  output int       mismatches,
  output int       pending
);

  localparam logic [71:0] LLP_TAG  = "[LLP v=2]";
  localparam logic [7:0]  NUL_BYTE = 8'h00;

  logic [7:0]  asm_bytes [LINE_BYTES];
  int          asm_len;
  int          tag_pos;
  bit          tag_seen;
  bit          nul_seen;
  logic [7:0]  slot_bytes [RING_LINES][LINE_BYTES];
  int          slot_len [RING_LINES];
  int          wr_slot;
  int          rd_slot;
  int          held;
  int          rd_pos;
  logic [15:0] drops;
  tlr_out_t    due_replies [$];
  int          errs = 0;

  function automatic logic [7:0] tag_at(input int i);
    return LLP_TAG[71 - 8 * i -: 8];
  endfunction

  task automatic clear_line();
    asm_len  = 0;
    tag_pos  = 0;
    tag_seen = 0;
    nul_seen = 0;
  endtask

  task automatic track_beat(input tlr_in_t b);
    tlr_out_t r;
    r = '0;
    case (b.cmd)
      CMD_PUSH: begin
        if (b.data_byte == NEWLINE_BYTE) begin
          if (tag_seen) begin
            // drop the oldest line when full
            if (held >= RING_LINES) begin
              rd_pos  = 0;
              rd_slot = (rd_slot + 1) % RING_LINES;
              held--;
              if (drops != DROP_MAX) drops++;
            end
            for (int i = 0; i < asm_len; i++) slot_bytes[wr_slot][i] = asm_bytes[i];
            slot_len[wr_slot] = asm_len;
            wr_slot = (wr_slot + 1) % RING_LINES;
            held++;
          end
          clear_line();
        end else if (asm_len < LINE_BYTES - 1) begin
          asm_bytes[asm_len] = b.data_byte;
          asm_len++;
          if (b.data_byte == NUL_BYTE) begin
            nul_seen = 1;
          end else if (!tag_seen && !nul_seen) begin
            if (b.data_byte == tag_at(tag_pos)) tag_pos++;
            else tag_pos = (b.data_byte == tag_at(0)) ? 1 : 0;
            if (tag_pos == int'(TAG_LEN)) tag_seen = 1;
          end
        end
      end
      CMD_READ: begin
        r.kind = KIND_EMPTY;
        if (held != 0) begin
          r.kind         = KIND_LINE;
          r.out_byte     = slot_bytes[rd_slot][rd_pos];
          r.last_of_line = (rd_pos + 1 >= slot_len[rd_slot]);
          if (r.last_of_line) begin
            rd_slot = (rd_slot + 1) % RING_LINES;
            held--;
            rd_pos = 0;
          end else begin
            rd_pos++;
          end
        end
        due_replies.push_back(r);
      end
      CMD_REPORT: begin
        r.kind          = KIND_REPORT;
        r.dropped_lines = drops;
        drops           = '0;
        due_replies.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    tlr_out_t want;
    if (!rst_n) begin
      clear_line();
      wr_slot = 0;
      rd_slot = 0;
      held    = 0;
      rd_pos  = 0;
      drops   = '0;
      due_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_replies.size() == 0) begin
          errs++;
          $display("%0t: unexpected beat kind %0d byte %h last %0d drops %0d", $time,
                   out_data.kind, out_data.out_byte, out_data.last_of_line,
                   out_data.dropped_lines);
        end else begin
          want = due_replies.pop_front();
          if (out_data.kind !== want.kind || out_data.out_byte !== want.out_byte ||
              out_data.last_of_line !== want.last_of_line ||
              out_data.dropped_lines !== want.dropped_lines) begin
            errs++;
            $display("%0t: expected kind %0d byte %h last %0d drops %0d", $time,
                     want.kind, want.out_byte, want.last_of_line, want.dropped_lines);
            $display("%0t: actual   kind %0d byte %h last %0d drops %0d", $time,
                     out_data.kind, out_data.out_byte, out_data.last_of_line,
                     out_data.dropped_lines);
          end
        end
      end
      if (in_valid && !in_stall) track_beat(in_data);
    end
    mismatches <= errs;
    pending    <= due_replies.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import tlr_pkg::*;

  localparam int          RING_LINES     = 32;
  localparam int          LINE_BYTES     = 256;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam logic [71:0] LLP_TAG        = "[LLP v=2]";
  localparam logic [7:0]  NUL_BYTE       = 8'h00;
  localparam int          RANDOM_BEATS   = 1000;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          RUN_LIMIT      = 200000;

  localparam int LINE_TAGGED    = 0;
  localparam int LINE_NOISE     = 1;
  localparam int LINE_NUL_FIRST = 2;
  localparam int LINE_RESTART   = 3;
  localparam int LINE_LONG      = 4;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  tlr_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall;
  tlr_out_t out_data;

  int mismatches;
  int pending;
  int cycle_count = 0;
  int beats_sent = 0;
  bit no_gaps = 0;
  bit hold_rx = 0;

  tagged_line_drop_oldest_ring_core #(
    .RING_LINES(RING_LINES),
    .LINE_BYTES(LINE_BYTES)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  line_ring_checker #(
    .RING_LINES(RING_LINES),
    .LINE_BYTES(LINE_BYTES)
  ) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  task automatic send_beat(input logic [1:0] op, input logic [7:0] value);
    tlr_in_t beat;
    int      gap;
    beat.cmd       = op;
    beat.data_byte = value;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic push_tag(input int count);
    for (int i = 0; i < count; i++) send_beat(CMD_PUSH, LLP_TAG[71 - 8 * i -: 8]);
  endtask

  function automatic logic [7:0] filler();
    logic [7:0] b;
    if ($urandom_range(0, 7) == 0) b = 8'($urandom_range(0, 255));
    else b = 8'($urandom_range(33, 126));
    if (b == NEWLINE_BYTE) b = b ^ 8'h01;
    return b;
  endfunction

  task automatic read_some(input int count);
    repeat (count) begin
      if ($urandom_range(0, 7) == 0) send_beat(CMD_REPORT, 8'($urandom_range(0, 255)));
      else send_beat(CMD_READ, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic push_line(input int shape);
    int pre;
    int post;
    int span;
    int at;
    pre  = $urandom_range(0, 4);
    post = $urandom_range(0, 4);
    repeat (pre) send_beat(CMD_PUSH, filler());
    case (shape)
      LINE_TAGGED: push_tag(int'(TAG_LEN));
      LINE_NUL_FIRST: begin
        send_beat(CMD_PUSH, NUL_BYTE);
        push_tag(int'(TAG_LEN));
      end
      LINE_RESTART: begin
        push_tag($urandom_range(1, int'(TAG_LEN) - 1));
        push_tag(int'(TAG_LEN));
      end
      LINE_LONG: begin
        span = LINE_BYTES + $urandom_range(0, 40);
        // place the tag anywhere, or just inside or just past the end of the kept part
        if ($urandom_range(0, 1)) at = $urandom_range(0, LINE_BYTES);
        else at = LINE_BYTES - 10 - pre + $urandom_range(0, 1);
        for (int i = 0; i < span; i++) begin
          if (i == at) push_tag(int'(TAG_LEN));
          else send_beat(CMD_PUSH, filler());
        end
      end
      default: begin
      end
    endcase
    if ($urandom_range(0, 5) == 0) read_some($urandom_range(1, 2));
    repeat (post) send_beat(CMD_PUSH, filler());
    send_beat(CMD_PUSH, NEWLINE_BYTE);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : result_side
    int n;
    bit rx_quiet;
    bit hold_done;
    rx_quiet  = 0;
    hold_done = 0;
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 19) == 0) rx_quiet = !rx_quiet;
      n = rx_quiet ? 0 : $urandom_range(0, 17);
      if (hold_rx && !hold_done) begin
        n = HOLD_CYCLES;
        hold_done = 1;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin : stimulus
    int read_bias;
    int lines_done;
    int pick;
    int shape;
    read_bias  = 0;
    lines_done = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_beat(CMD_READ, 8'hFF);
    send_beat(CMD_REPORT, 8'h00);
    send_beat(CMD_UNUSED, 8'hA5);
    push_tag(int'(TAG_LEN));
    send_beat(CMD_PUSH, NUL_BYTE);
    send_beat(CMD_PUSH, 8'hFF);
    send_beat(CMD_PUSH, NEWLINE_BYTE);
    send_beat(CMD_READ, 8'h00);
    send_beat(CMD_READ, 8'hFF);
    send_beat(CMD_REPORT, 8'hFF);

    // fill past capacity, reading now and then so that partly read lines drop
    for (int n = 0; n < RING_LINES + 8; n++) begin
      push_line(n == 0 ? LINE_LONG : LINE_TAGGED);
      if ($urandom_range(0, 5) == 0) read_some($urandom_range(1, 3));
    end

    // hold the result side while reads keep coming
    hold_rx = 1;
    no_gaps = 1;
    read_some(60);
    no_gaps = 0;
    wait_drained();

    while (beats_sent < RANDOM_BEATS) begin
      if (lines_done % 8 == 0) read_bias = $urandom_range(0, 3);
      no_gaps = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 39);
      if (pick == 0) shape = LINE_LONG;
      else if (pick < 5) shape = LINE_NOISE;
      else if (pick < 8) shape = LINE_NUL_FIRST;
      else if (pick < 12) shape = LINE_RESTART;
      else shape = LINE_TAGGED;
      push_line(shape);
      lines_done++;
      if ($urandom_range(0, 1)) read_some($urandom_range(0, read_bias * 8));
      if ($urandom_range(0, 15) == 0) send_beat(CMD_UNUSED, 8'($urandom_range(0, 255)));
    end

    no_gaps = 0;
    send_beat(CMD_REPORT, 8'h00);
    repeat (RING_LINES * 4) send_beat(CMD_READ, 8'($urandom_range(0, 255)));

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
